[rtl/core/owm_pkg.sv]
package owm_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_RESET_LOW    = 3'd0;
   localparam logic [2:0] REG_PRESENCE     = 3'd1;
   localparam logic [2:0] REG_RESET_TAIL   = 3'd2;
   localparam logic [2:0] REG_SHORT_LOW    = 3'd3;
   localparam logic [2:0] REG_LONG_LOW     = 3'd4;
   localparam logic [2:0] REG_SAMPLE_DELAY = 3'd5;
   localparam logic [2:0] REG_SLOT         = 3'd6;

   localparam int CSR_ADDR_W = 5;

   // register reset values
   localparam logic [9:0] RESET_LOW_DEF    = 10'd480;
   localparam logic [9:0] PRESENCE_DEF     = 10'd70;
   localparam logic [9:0] RESET_TAIL_DEF   = 10'd410;
   localparam logic [7:0] SHORT_LOW_DEF    = 8'd6;
   localparam logic [7:0] LONG_LOW_DEF     = 8'd60;
   localparam logic [7:0] SAMPLE_DELAY_DEF = 8'd9;
   localparam logic [7:0] SLOT_DEF         = 8'd70;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_RST_LOW   = 7'b0000010,
      PH_RST_WAIT  = 7'b0000100,
      PH_RST_TAIL  = 7'b0001000,
      PH_SLOT_LOW  = 7'b0010000,
      PH_RD_WAIT   = 7'b0100000,
      PH_SLOT_TAIL = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [9:0] presence_sample_time;
      logic [9:0] reset_tail_time;
      logic [7:0] short_low_time;
      logic [7:0] long_low_time;
      logic [7:0] read_sample_delay;
      logic [7:0] slot_time;
   } cfg_type;

   typedef struct packed {
      logic       command_ignored;
      logic       presence_level;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       bus_drive;
   } result_type;

endpackage

[rtl/core/owm_csr.sv]
module owm_csr
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RESET_LOW:    cfg_in.reset_low_time       = csr_pwdata[9:0];
            REG_PRESENCE:     cfg_in.presence_sample_time = csr_pwdata[9:0];
            REG_RESET_TAIL:   cfg_in.reset_tail_time      = csr_pwdata[9:0];
            REG_SHORT_LOW:    cfg_in.short_low_time       = csr_pwdata[7:0];
            REG_LONG_LOW:     cfg_in.long_low_time        = csr_pwdata[7:0];
            REG_SAMPLE_DELAY: cfg_in.read_sample_delay    = csr_pwdata[7:0];
            REG_SLOT:         cfg_in.slot_time            = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RESET_LOW:    csr_prdata = {22'd0, cfg_ff.reset_low_time};
         REG_PRESENCE:     csr_prdata = {22'd0, cfg_ff.presence_sample_time};
         REG_RESET_TAIL:   csr_prdata = {22'd0, cfg_ff.reset_tail_time};
         REG_SHORT_LOW:    csr_prdata = {24'd0, cfg_ff.short_low_time};
         REG_LONG_LOW:     csr_prdata = {24'd0, cfg_ff.long_low_time};
         REG_SAMPLE_DELAY: csr_prdata = {24'd0, cfg_ff.read_sample_delay};
         REG_SLOT:         csr_prdata = {24'd0, cfg_ff.slot_time};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time       <= RESET_LOW_DEF;
         cfg_ff.presence_sample_time <= PRESENCE_DEF;
         cfg_ff.reset_tail_time      <= RESET_TAIL_DEF;
         cfg_ff.short_low_time       <= SHORT_LOW_DEF;
         cfg_ff.long_low_time        <= LONG_LOW_DEF;
         cfg_ff.read_sample_delay    <= SAMPLE_DELAY_DEF;
         cfg_ff.slot_time            <= SLOT_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/owm_engine.sv]
module owm_engine
   import owm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] op,
   input  logic [7:0] write_data,
   input  logic       bus_level,
   input  cfg_type    cfg,
   output result_type res
);

   phase_type  phase_ff, phase_in;
   logic [9:0] count_ff, count_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       drive_ff, drive_in;
   logic       presence_ff, presence_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] last_read_ff, last_read_in;
   logic       done;
   logic       ignored;
   logic [9:0] count_inc;
   logic [7:0] low_time;
   logic [8:0] sample_time;
   logic       busy;

   assign busy        = (phase_ff != PH_IDLE);
   assign count_inc   = count_ff + 10'd1;
   assign low_time    = (is_read_ff || shift_ff[0]) ? cfg.short_low_time : cfg.long_low_time;
   assign sample_time = {1'b0, cfg.short_low_time} + {1'b0, cfg.read_sample_delay};

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      drive_in     = drive_ff;
      presence_in  = presence_ff;
      is_read_in   = is_read_ff;
      last_read_in = last_read_ff;
      done         = 1'b0;
      ignored      = 1'b0;

      if (op == OP_TICK) begin
         if (busy) begin
            count_in = count_inc;
            case (phase_ff)
               PH_RST_LOW: begin
                  if (count_inc >= cfg.reset_low_time) begin
                     drive_in = 1'b1;
                     count_in = 10'd0;
                     phase_in = PH_RST_WAIT;
                  end
               end
               PH_RST_WAIT: begin
                  if (count_inc >= cfg.presence_sample_time) begin
                     presence_in = bus_level;
                     count_in    = 10'd0;
                     phase_in    = PH_RST_TAIL;
                  end
               end
               PH_RST_TAIL: begin
                  if (count_inc >= cfg.reset_tail_time) begin
                     phase_in = PH_IDLE;
                     count_in = 10'd0;
                     done     = 1'b1;
                  end
               end
               PH_SLOT_LOW: begin
                  if (count_inc >= {2'd0, low_time}) begin
                     drive_in = 1'b1;
                     if (is_read_ff) begin
                        phase_in = PH_RD_WAIT;
                     end else begin
                        shift_in = {1'b0, shift_ff[7:1]};
                        phase_in = PH_SLOT_TAIL;
                     end
                  end
               end
               PH_RD_WAIT: begin
                  if (count_inc >= {1'b0, sample_time}) begin
                     shift_in = {bus_level, shift_ff[7:1]};
                     phase_in = PH_SLOT_TAIL;
                  end
               end
               PH_SLOT_TAIL: begin
                  if (count_inc >= {2'd0, cfg.slot_time}) begin
                     if (bit_ff == 3'd7) begin
                        bit_in   = 3'd0;
                        count_in = 10'd0;
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                        if (is_read_ff) begin
                           last_read_in = shift_ff;
                        end
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        count_in = 10'd0;
                        drive_in = 1'b0;
                        phase_in = PH_SLOT_LOW;
                     end
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end else if (busy) begin
         ignored = 1'b1;
      end else if (op == OP_RESET) begin
         count_in = 10'd0;
         drive_in = 1'b0;
         phase_in = PH_RST_LOW;
      end else begin
         // write or read byte, first slot starts low at once
         is_read_in = (op == OP_READ);
         shift_in   = (op == OP_READ) ? 8'd0 : write_data;
         bit_in     = 3'd0;
         count_in   = 10'd0;
         drive_in   = 1'b0;
         phase_in   = PH_SLOT_LOW;
      end
   end

   assign res.bus_drive       = drive_in;
   assign res.busy_res        = (phase_in != PH_IDLE);
   assign res.done_res        = done;
   assign res.read_data       = last_read_in;
   assign res.presence_level  = presence_in;
   assign res.command_ignored = ignored;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= 10'd0;
         bit_ff       <= 3'd0;
         shift_ff     <= 8'd0;
         drive_ff     <= 1'b1;
         presence_ff  <= 1'b1;
         is_read_ff   <= 1'b0;
         last_read_ff <= 8'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         drive_ff     <= drive_in;
         presence_ff  <= presence_in;
         is_read_ff   <= is_read_in;
         last_read_ff <= last_read_in;
      end
   end

`ifndef SYNTHESIS
   // line is released whenever no operation runs
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> drive_ff)
      else $error("line driven low while idle");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (bit_ff == 3'd0))
      else $error("bit position not cleared while idle");

   assert property (@(posedge clock) disable iff (reset)
      (step && done) |=> (phase_ff == PH_IDLE))
      else $error("finished operation did not return to idle");
`endif

endmodule

[rtl/core/one_wire_bus_master.sv]
// 1-wire bus master stepped by one-microsecond tick requests
// path: a request is held in the input register, then its result in the result register, before it shows on rsp_
// throughput: one request per cycle while rsp_tready holds, an input register and a result register
//    let a new request in while an earlier result waits to be taken
// reset: synchronous, active high; idle, line driven high, presence reads 1,
//    timing registers back to their default values
module one_wire_bus_master
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // write_data[7:0], bus_level[8], zero pad
   input  logic [1:0]            req_tuser,  // operation[1:0]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // bus_drive[0], busy_res[1], done_res[2],
                                             // read_data[10:3], presence_level[11],
                                             // command_ignored[12], zero pad
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type step_res;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_op_ff;
   logic [7:0] in_data_ff;
   logic       in_level_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic       req_fire;
   logic       step;

   // the request in the input register is processed when the result slot frees up
   assign step        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_res_ff};

   owm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // bus state machine, advances once per processed request
   owm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .op         (in_op_ff),
      .write_data (in_data_ff),
      .bus_level  (in_level_ff),
      .cfg        (cfg),
      .res        (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff    <= req_tuser;
         in_data_ff  <= req_tdata[7:0];
         in_level_ff <= req_tdata[8];
      end
      if (step) begin
         out_res_ff <= step_res;
      end
   end

`ifndef SYNTHESIS
   // both registers full and the result stalled: no request may enter
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted with both stages full");

   // a finishing request always leaves the master idle
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.done_res) |-> !out_res_ff.busy_res)
      else $error("done reported while still busy");

   // a dropped command only happens while busy and never finishes anything
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.command_ignored) |->
         (out_res_ff.busy_res && !out_res_ff.done_res))
      else $error("ignored command while idle or finishing");
`endif

endmodule

[tb/one_wire_checker.sv]
module one_wire_checker
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,  // write_data[7:0], bus_level[8], zero pad
   input  logic [1:0]            req_tuser,  // operation[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,  // bus_drive[0], busy_res[1], done_res[2],
                                             // read_data[10:3], presence_level[11],
                                             // command_ignored[12], zero pad
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    mismatches,
   output int                    outstanding,
   output logic                  line_active,
   output int                    ops_finished,
   output int                    cmds_dropped,
   output int                    rsp_checked
);

   // predicted bus master state
   cfg_type    timing;
   phase_type  phase;
   logic [9:0] usec;
   logic [2:0] bit_idx;
   logic [7:0] shift_byte;
   logic       drive;
   logic       presence;
   logic       reading;
   logic [7:0] last_read;

   result_type predicted_rsp[$];
   int         err_total;
   int         finished_total;
   int         dropped_total;
   int         checked_total;

   // only the first 50 are printed, all are counted
   task automatic report(input string field, input int want, input int got);
      if (err_total < 50) begin
         $display("%0t: mismatch on %s, expected %0d, got %0d", $time, field, want, got);
      end
      err_total++;
   endtask

   // one request through the bus master, returns the result it must produce
   function automatic result_type advance_bus(input logic [1:0] op, input logic [7:0] data,
                                              input logic level);
      result_type r;
      logic       fin;
      logic       dropped;
      logic [9:0] low_end;
      fin = 1'b0;
      dropped = 1'b0;
      if (op == OP_TICK) begin
         if (phase != PH_IDLE) begin
            usec = usec + 10'd1;
            case (phase)
               PH_RST_LOW: if (usec >= timing.reset_low_time) begin
                  drive = 1'b1;
                  usec = '0;
                  phase = PH_RST_WAIT;
               end
               PH_RST_WAIT: if (usec >= timing.presence_sample_time) begin
                  presence = level;
                  usec = '0;
                  phase = PH_RST_TAIL;
               end
               PH_RST_TAIL: if (usec >= timing.reset_tail_time) begin
                  phase = PH_IDLE;
                  usec = '0;
                  fin = 1'b1;
               end
               PH_SLOT_LOW: begin
                  low_end = (reading || shift_byte[0]) ? {2'b00, timing.short_low_time}
                                                       : {2'b00, timing.long_low_time};
                  if (usec >= low_end) begin
                     drive = 1'b1;
                     if (reading) begin
                        phase = PH_RD_WAIT;
                     end else begin
                        shift_byte = shift_byte >> 1;
                        phase = PH_SLOT_TAIL;
                     end
                  end
               end
               PH_RD_WAIT: if (usec >= {2'b00, timing.short_low_time}
                                       + {2'b00, timing.read_sample_delay}) begin
                  shift_byte = {level, shift_byte[7:1]};
                  phase = PH_SLOT_TAIL;
               end
               PH_SLOT_TAIL: if (usec >= {2'b00, timing.slot_time}) begin
                  if (bit_idx == 3'd7) begin
                     bit_idx = '0;
                     usec = '0;
                     phase = PH_IDLE;
                     if (reading) last_read = shift_byte;
                     fin = 1'b1;
                  end else begin
                     bit_idx = bit_idx + 3'd1;
                     usec = '0;
                     drive = 1'b0;
                     phase = PH_SLOT_LOW;
                  end
               end
               default: phase = PH_IDLE;
            endcase
         end
      end else if (phase != PH_IDLE) begin
         dropped = 1'b1;
      end else if (op == OP_RESET) begin
         usec = '0;
         drive = 1'b0;
         phase = PH_RST_LOW;
      end else begin
         reading = (op == OP_READ);
         shift_byte = reading ? 8'd0 : data;
         bit_idx = '0;
         usec = '0;
         drive = 1'b0;
         phase = PH_SLOT_LOW;
      end
      r.bus_drive       = drive;
      r.busy_res        = (phase != PH_IDLE);
      r.done_res        = fin;
      r.read_data       = last_read;
      r.presence_level  = presence;
      r.command_ignored = dropped;
      return r;
   endfunction

   always @(posedge clock) begin : track
      result_type want;
      result_type got;
      if (reset) begin
         timing = {RESET_LOW_DEF, PRESENCE_DEF, RESET_TAIL_DEF, SHORT_LOW_DEF,
                   LONG_LOW_DEF, SAMPLE_DELAY_DEF, SLOT_DEF};
         phase = PH_IDLE;
         usec = '0;
         bit_idx = '0;
         shift_byte = '0;
         drive = 1'b1;
         presence = 1'b1;
         reading = 1'b0;
         last_read = '0;
         predicted_rsp.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_RESET_LOW:    timing.reset_low_time       = csr_pwdata[9:0];
               REG_PRESENCE:     timing.presence_sample_time = csr_pwdata[9:0];
               REG_RESET_TAIL:   timing.reset_tail_time      = csr_pwdata[9:0];
               REG_SHORT_LOW:    timing.short_low_time       = csr_pwdata[7:0];
               REG_LONG_LOW:     timing.long_low_time        = csr_pwdata[7:0];
               REG_SAMPLE_DELAY: timing.read_sample_delay    = csr_pwdata[7:0];
               REG_SLOT:         timing.slot_time            = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_rsp.size() == 0) begin
               report("result with nothing pending", 0, int'(rsp_tdata));
            end else begin
               want = predicted_rsp.pop_front();
               got = rsp_tdata[12:0];
               checked_total++;
               if (got.bus_drive !== want.bus_drive)
                  report("bus_drive", int'(want.bus_drive), int'(got.bus_drive));
               if (got.busy_res !== want.busy_res)
                  report("busy_res", int'(want.busy_res), int'(got.busy_res));
               if (got.done_res !== want.done_res)
                  report("done_res", int'(want.done_res), int'(got.done_res));
               if (got.read_data !== want.read_data)
                  report("read_data", int'(want.read_data), int'(got.read_data));
               if (got.presence_level !== want.presence_level)
                  report("presence_level", int'(want.presence_level),
                         int'(got.presence_level));
               if (got.command_ignored !== want.command_ignored)
                  report("command_ignored", int'(want.command_ignored),
                         int'(got.command_ignored));
               if (rsp_tdata[15:13] !== 3'd0)
                  report("padding", 0, int'(rsp_tdata[15:13]));
            end
         end
         if (req_tvalid && req_tready) begin
            want = advance_bus(req_tuser, req_tdata[7:0], req_tdata[8]);
            if (want.done_res) finished_total++;
            if (want.command_ignored) dropped_total++;
            predicted_rsp.push_back(want);
         end
      end
      mismatches   <= err_total;
      outstanding  <= predicted_rsp.size();
      line_active  <= (phase != PH_IDLE);
      ops_finished <= finished_total;
      cmds_dropped <= dropped_total;
      rsp_checked  <= checked_total;
   end

endmodule

[tb/tb_top.sv]
module tb_top;
   import owm_pkg::*;

   // cycles with no handshake on any port before the run is declared hung
   localparam int STALL_LIMIT = 2000;

   // how the sampled line level is chosen for tick requests
   typedef enum {LEVEL_LOW, LEVEL_HIGH, LEVEL_RANDOM} level_mode_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata   = '0;  // write_data[7:0], bus_level[8], zero pad
   logic [1:0]            req_tuser   = OP_TICK;  // operation[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [15:0]           rsp_tdata;  // bus_drive[0], busy_res[1], done_res[2],
                                      // read_data[10:3], presence_level[11],
                                      // command_ignored[12], zero pad
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // checker outputs
   int   mismatches;
   int   outstanding;
   logic line_active;
   int   ops_finished;
   int   cmds_dropped;
   int   rsp_checked;

   // stimulus bookkeeping
   bit   sender_gaps = 1'b0;
   bit   sink_stalls = 1'b0;
   int   sent_items  = 0;
   int   ops_started = 0;
   int   settings_used = 0;

   one_wire_bus_master dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   one_wire_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .line_active  (line_active),
      .ops_finished (ops_finished),
      .cmds_dropped (cmds_dropped),
      .rsp_checked  (rsp_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side backpressure: random stall bursts while enabled
   initial begin
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // hang detection: any handshake or register access resets the count
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // one request, with an optional gap in front; returns at the accepting edge
   task automatic push_request(input logic [1:0] op, input logic [7:0] data,
                               input logic level);
      if (sender_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, level, data};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   // one microsecond tick, write_data is don't-care so it gets noise
   task automatic push_tick(input level_mode_type mode);
      logic level;
      case (mode)
         LEVEL_LOW:  level = 1'b0;
         LEVEL_HIGH: level = 1'b1;
         default:    level = 1'($urandom_range(0, 1));
      endcase
      push_request(OP_TICK, 8'($urandom), level);
   endtask

   // tick until the predicted operation ends; noisy mode sprinkles in
   // commands that arrive while busy and must be dropped
   task automatic finish_op(input level_mode_type mode, input bit noisy);
      do begin
         if (noisy && $urandom_range(0, 29) == 0)
            push_request(2'($urandom_range(1, 3)), 8'($urandom),
                         1'($urandom_range(0, 1)));
         else
            push_tick(mode);
      end while (line_active);
   endtask

   task automatic run_op(input logic [1:0] op, input logic [7:0] data,
                         input level_mode_type mode, input bit noisy);
      push_request(op, data, 1'($urandom_range(0, 1)));
      ops_started++;
      finish_op(mode, noisy);
   endtask

   // stop sending and let every predicted result come back
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // pipeline depth of two plus margin
      repeat (4) @(posedge clock);
   endtask

   // apb write: setup then access, register taken when pready is high
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_timing(input int rst_low, input int pres, input int rst_tail,
                              input int short_low, input int long_low,
                              input int delay, input int slot);
      settle();
      write_reg(REG_RESET_LOW, rst_low);
      write_reg(REG_PRESENCE, pres);
      write_reg(REG_RESET_TAIL, rst_tail);
      write_reg(REG_SHORT_LOW, short_low);
      write_reg(REG_LONG_LOW, long_low);
      write_reg(REG_SAMPLE_DELAY, delay);
      write_reg(REG_SLOT, slot);
      settings_used++;
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;

      // ---- directed part, reset timing values first
      // ticks while idle change nothing
      push_request(OP_TICK, 8'hFF, 1'b1);
      push_request(OP_TICK, 8'h00, 1'b0);
      // reset pulse at default timing with a device answering, a read dropped
      // mid-pulse, then the pulse cut short by smaller reset times
      push_request(OP_RESET, 8'h00, 1'b1);
      ops_started++;
      push_request(OP_READ, 8'hFF, 1'b1);
      repeat (20) push_tick(LEVEL_LOW);
      settle();
      write_reg(REG_RESET_LOW, 3);
      write_reg(REG_PRESENCE, 4);
      write_reg(REG_RESET_TAIL, 5);
      finish_op(LEVEL_LOW, 1'b0);
      // byte write at default slot timing, slots shortened part way through
      push_request(OP_WRITE, 8'hA5, 1'b0);
      ops_started++;
      repeat (20) push_tick(LEVEL_RANDOM);
      settle();
      write_reg(REG_SHORT_LOW, 2);
      write_reg(REG_LONG_LOW, 3);
      write_reg(REG_SLOT, 5);
      finish_op(LEVEL_RANDOM, 1'b0);

      // shortest legal timing everywhere
      load_timing(1, 1, 1, 1, 1, 1, 2);
      run_op(OP_RESET, 8'h00, LEVEL_HIGH, 1'b0);
      run_op(OP_WRITE, 8'h00, LEVEL_RANDOM, 1'b0);
      run_op(OP_WRITE, 8'hFF, LEVEL_RANDOM, 1'b0);
      run_op(OP_READ, 8'h00, LEVEL_LOW, 1'b0);
      run_op(OP_READ, 8'hFF, LEVEL_HIGH, 1'b0);

      // longest timing everywhere, a reset and a read started then cut short
      load_timing(1023, 1023, 1023, 255, 255, 255, 255);
      push_request(OP_RESET, 8'h00, 1'b0);
      ops_started++;
      repeat (12) push_tick(LEVEL_RANDOM);
      load_timing(2, 2, 2, 1, 1, 1, 2);
      finish_op(LEVEL_LOW, 1'b0);
      load_timing(1023, 1023, 1023, 255, 255, 255, 255);
      push_request(OP_READ, 8'h00, 1'b0);
      ops_started++;
      repeat (12) push_tick(LEVEL_RANDOM);
      load_timing(2, 2, 2, 1, 1, 1, 2);
      finish_op(LEVEL_RANDOM, 1'b0);

      // zero short low and read delay, slot shorter than the zero-bit low time
      load_timing(5, 3, 4, 0, 12, 0, 2);
      run_op(OP_WRITE, 8'h5A, LEVEL_RANDOM, 1'b0);
      run_op(OP_READ, 8'h00, LEVEL_RANDOM, 1'b0);

      // timing changed while a byte is on the wire
      push_request(OP_WRITE, 8'hC3, 1'b0);
      ops_started++;
      repeat (30) push_tick(LEVEL_RANDOM);
      settle();
      write_reg(REG_LONG_LOW, 7);
      write_reg(REG_SLOT, 9);
      finish_op(LEVEL_RANDOM, 1'b0);

      // ---- random part: mostly whole operations with small timing so many
      // finish, some stray requests, gaps and stalls switched per setting
      while (sent_items < 460) begin
         load_timing($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                     $urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 4),
                     $urandom_range(2, 8));
         sender_gaps = ($urandom_range(0, 3) != 0);
         sink_stalls = ($urandom_range(0, 3) != 0);
         repeat (4) begin
            if ($urandom_range(0, 99) < 85) begin
               run_op(2'($urandom_range(1, 3)), 8'($urandom), LEVEL_RANDOM, 1'b1);
            end else begin
               repeat ($urandom_range(1, 4))
                  push_request(2'($urandom_range(0, 3)), 8'($urandom),
                               1'($urandom_range(0, 1)));
            end
         end
      end

      // closing stretch at full rate on both sides
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      load_timing($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                  $urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 4),
                  $urandom_range(2, 8));
      repeat (3) run_op(2'($urandom_range(1, 3)), 8'($urandom), LEVEL_RANDOM, 1'b1);

      // drain, then a few more cycles for anything unexpected to show up
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d requests, checked %0d results over %0d timing settings",
               sent_items, rsp_checked, settings_used + 1);
      $display("%0d bus operations completed, %0d commands dropped while busy",
               ops_finished, cmds_dropped);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
